[sv/cis_pkg.sv]
// Shared types and constants for the circle inlier select block.
`timescale 1ns / 1ps
`default_nettype none
package cis_pkg;
	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 24;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int RAD_W      = 23;
	localparam int DIFF_W     = COORD_BITS;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int N_W        = SQ_W + 2;
	localparam int ROOT_W     = DIFF_W + 1;
	localparam int RES_W      = 26;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	localparam logic [1:0] REG_CENTER_X  = 2'd0;
	localparam logic [1:0] REG_CENTER_Y  = 2'd1;
	localparam logic [1:0] REG_RADIUS    = 2'd2;
	localparam logic [1:0] REG_THRESHOLD = 2'd3;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         has_point;
		logic                         last_in_measure;
	} in_t;

	typedef struct packed {
		logic       found;
		logic [7:0] point_index;
	} out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [RAD_W-1:0]             radius;
		logic [RAD_W-1:0]             inlier_threshold;
	} cfg_t;

	typedef struct packed {
		logic            has_point;
		logic            last_in_measure;
		logic [SQ_W-1:0] dx2;
		logic [SQ_W-1:0] dy2;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;
endpackage
`default_nettype wire

[sv/cis_front.sv]
// Front end: accepts points, forms squared center offsets.
`timescale 1ns / 1ps
`default_nettype none
module cis_front import cis_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire in_t    in_item,
	input  wire cfg_t   cfg,
	input  wire logic   fifo_full,
	output logic        push,
	output entry_t      push_entry
);
	logic              v_s1, v_s2;
	logic [DIFF_W-1:0] dx_s1, dy_s1;
	logic              has_s1, last_s1;
	entry_t            ent_s2;
	logic              adv1, adv2;
	logic signed [DIFF_W:0] diff_x, diff_y;

	assign adv2 = !v_s2 || !fifo_full;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign push = v_s2 && !fifo_full;
	assign push_entry = ent_s2;

	assign diff_x = {in_item.point_x[COORD_BITS-1], in_item.point_x}
		- {cfg.center_x[COORD_BITS-1], cfg.center_x};
	assign diff_y = {in_item.point_y[COORD_BITS-1], in_item.point_y}
		- {cfg.center_y[COORD_BITS-1], cfg.center_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			dx_s1   <= diff_x[DIFF_W] ? DIFF_W'(-diff_x) : diff_x[DIFF_W-1:0];
			dy_s1   <= diff_y[DIFF_W] ? DIFF_W'(-diff_y) : diff_y[DIFF_W-1:0];
			has_s1  <= in_item.has_point;
			last_s1 <= in_item.last_in_measure;
		end
		if (adv2 && v_s1) begin
			ent_s2.dx2             <= dx_s1 * dx_s1;
			ent_s2.dy2             <= dy_s1 * dy_s1;
			ent_s2.has_point       <= has_s1;
			ent_s2.last_in_measure <= last_s1;
		end
	end
endmodule
`default_nettype wire

[sv/cis_fifo.sv]
// Short queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module cis_fifo import cis_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire entry_t  push_entry,
	input  wire logic    pop,
	output entry_t       head,
	output fifo_status_t status
);
	entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     cnt_q;

	assign status.full  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end
endmodule
`default_nettype wire

[sv/cis_back.sv]
// Back end: bit-serial square root, residual test, best tracking, result.
`timescale 1ns / 1ps
`default_nettype none
module cis_back import cis_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire entry_t head,
	input  wire logic   fifo_empty,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output out_t        out_item
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROOT = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t           st_q;
	logic [N_W-1:0]   n_q, root_q, bit_q, trial;
	logic             last_q;
	logic [RES_W-1:0] best_res_q, resid;
	logic [7:0]       best_pos_q;
	logic             have_best_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROOT_W-1:0] dist_val;
	logic             room;

	assign pop = (st_q == ST_IDLE) && !fifo_empty;
	assign room = cnt_q < CNT_W'(MAX_POINTS);
	assign trial = root_q + bit_q;
	assign dist_val = root_q[ROOT_W-1:0];
	assign resid = (dist_val >= ROOT_W'(cfg.radius))
		? RES_W'(dist_val - ROOT_W'(cfg.radius))
		: RES_W'(ROOT_W'(cfg.radius) - dist_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid   <= 1'b0;
			best_res_q  <= '1;
			best_pos_q  <= '0;
			have_best_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// in ST_EMIT the emit arm alone drives out_valid
			if (out_valid && !out_stall && st_q != ST_EMIT) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						last_q <= head.last_in_measure;
						if (head.has_point && room) begin
							n_q    <= N_W'(head.dx2) + N_W'(head.dy2);
							root_q <= '0;
							bit_q  <= N_W'(1) << (N_W - 2);
							st_q   <= ST_ROOT;
						end else if (!head.has_point || head.last_in_measure) begin
							st_q <= ST_EMIT;
						end
					end
				end
				ST_ROOT: begin
					if (n_q >= trial) begin
						n_q    <= n_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (resid < best_res_q && resid < RES_W'(cfg.inlier_threshold)) begin
						best_res_q  <= resid;
						best_pos_q  <= cnt_q[7:0];
						have_best_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					st_q  <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						out_valid            <= 1'b1;
						out_item.found       <= have_best_q;
						out_item.point_index <= have_best_q ? best_pos_q : 8'd0;
						best_res_q  <= '1;
						best_pos_q  <= '0;
						have_best_q <= 1'b0;
						cnt_q       <= '0;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/circle_inlier_select.sv]
// Top level of the circle inlier select block.
// Usage:
//  Input channel in_valid/in_stall/in_item carries one edge point per item,
//  with has_point and last_in_measure marking measure boundaries.
//  Output channel out_valid/out_stall/out_item gives one result per closed
//  measure: found and the point's position in the measure.
//  Configuration is a write port (cfg_we, cfg_index, cfg_data) for center
//  x/y, radius, inlier threshold. Write only while idle; the block does not check.
//  The front end takes one item per cycle into a two stage offset/square
//  pipeline and a four entry queue, except while the queue is full and
//  both stages are occupied. The back end works on a point in steps (one
//  dequeue, 25 root steps, one compare), paced by the bit-serial square
//  root, and takes no new point until it is through with the last; items
//  without work take a dequeue and, if they close a measure, an emit.
//  Reset clears the pipeline, queue, running best and config registers.
//  A stalled result holds in the output register; the queue then fills and
//  the input side stalls.
`timescale 1ns / 1ps
`default_nettype none
module circle_inlier_select import cis_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_item,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	cfg_t         cfg_q;
	logic         push, pop;
	entry_t       push_entry, head;
	fifo_status_t fst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:  cfg_q.center_x <= cfg_data;
				REG_CENTER_Y:  cfg_q.center_y <= cfg_data;
				REG_RADIUS:    cfg_q.radius <= cfg_data[RAD_W-1:0];
				REG_THRESHOLD: cfg_q.inlier_threshold <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	cis_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .cfg(cfg_q),
		.fifo_full(fst.full), .push, .push_entry
	);

	cis_fifo u_fifo (
		.clk, .arst_n, .push, .push_entry, .pop, .head, .status(fst)
	);

	cis_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .head, .fifo_empty(fst.empty), .pop,
		.out_valid, .out_stall, .out_item
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fst.full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fst.empty) else $error("queue underflow");
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.found) |-> (out_item.point_index == 8'd0))
		else $error("index set without inlier");
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for circle_inlier_select: directed table plus random measures, scored by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import cis_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_item;
	logic        out_valid;
	logic        out_stall;
	out_t        out_item;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	circle_inlier_select dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of configuration and running best
	logic signed [23:0] m_cx, m_cy;
	logic [22:0]        m_rad, m_thr;
	logic [25:0]        m_best;
	logic [7:0]         m_pos;
	logic               m_have;
	int unsigned        m_count;

	out_t        verdicts[$];
	int          errors;
	int          send_idle_pct, recv_idle_pct;
	int          hold_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void clear_best();
		m_best = '1;
		m_pos = 0;
		m_have = 0;
		m_count = 0;
	endfunction

	// updates the running best; queues a verdict when the measure closes
	function automatic void predict_point(input in_t it);
		longint dx, dy;
		logic [63:0] d, res;
		out_t v;
		if (it.has_point) begin
			if (m_count < MAX_POINTS) begin
				dx = longint'(it.point_x) - longint'(m_cx);
				dy = longint'(it.point_y) - longint'(m_cy);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				d = root_floor(dx * dx + dy * dy);
				res = (d >= m_rad) ? d - m_rad : m_rad - d;
				if (res < m_best && res < m_thr) begin
					m_best = res[25:0];
					m_pos = m_count[7:0];
					m_have = 1;
				end
				m_count++;
			end
			if (!it.last_in_measure) return;
		end
		v.found = m_have;
		v.point_index = m_have ? m_pos : 8'd0;
		verdicts = {verdicts, v};
		clear_best();
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_CENTER_X:  m_cx = val;
			REG_CENTER_Y:  m_cy = val;
			REG_RADIUS:    m_rad = val[22:0];
			REG_THRESHOLD: m_thr = val[22:0];
		endcase
	endtask

	task automatic set_circle(input logic [23:0] cx, cy, rad, thr);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_THRESHOLD, thr);
	endtask

	// offer one item; returns at the falling edge after it is accepted, valid still high
	task automatic send_item(input in_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_point(it);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		int guard;
		in_valid <= 0;
		guard = 0;
		while (verdicts.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
	endtask

	function automatic in_t mk(input int x, y, bit h, bit l);
		in_t it;
		it.point_x = 24'(x);
		it.point_y = 24'(y);
		it.has_point = h;
		it.last_in_measure = l;
		return it;
	endfunction

	// random measure; mostly near the circle so inliers are common
	task automatic random_measure(input int n);
		in_t it;
		int r;
		for (int i = 0; i < n; i++) begin
			it.point_x = 24'($urandom);
			it.point_y = 24'($urandom);
			it.has_point = ($urandom_range(30) != 0);
			it.last_in_measure = (i == n - 1);
			if ($urandom_range(3) != 0) begin
				r = int'(m_rad) + $signed($urandom_range(2 * m_thr + 8)) - int'(m_thr) - 4;
				it.point_x = 24'(m_cx + ($urandom_range(1) ? r : -r));
				it.point_y = 24'(m_cy + $signed($urandom_range(15)) - 8);
			end
			send_item(it);
			if (!it.has_point) break;
		end
	endtask

	// receiver: random stalls, one long hold-off, checking against oldest verdict
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, out_item);
				errors++;
			end else begin
				e = verdicts.pop_front();
				if (out_item.found !== e.found || out_item.point_index !== e.point_index) begin
					$display("%0t: expected found=%0d index=%0d, got found=%0d index=%0d",
						$realtime, e.found, e.point_index, out_item.found, out_item.point_index);
					errors++;
				end
			end
		end
	end

	typedef struct {
		in_t  it;
		bit   known;
		out_t want;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		out_t w;
		errors = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = REG_CENTER_X;
		cfg_data = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		m_cx = 0; m_cy = 0; m_rad = 0; m_thr = 0;
		clear_best();
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset config (threshold 0) never finds
		w = '0;
		rows = {rows, stim_row_t'{mk(0, 0, 1, 1), 1, w}};
		rows = {rows, stim_row_t'{mk(-8388608, 8388607, 0, 0), 1, w}};
		rows = {rows, stim_row_t'{mk(8388607, -8388608, 1, 1), 1, w}};
		foreach (rows[i]) begin
			send_item(rows[i].it);
			if (rows[i].known && verdicts.size() != 0 && verdicts[$] != rows[i].want) begin
				$display("%0t: table row %0d expected %p", $realtime, i, rows[i].want);
				errors++;
			end
		end
		wait_drain();

		// radius 1.0, threshold 0.5: ties, empty close, close mid-measure
		set_circle(0, 0, 24'd256, 24'd128);
		rows = {};
		w.found = 1; w.point_index = 1;
		rows = {rows, stim_row_t'{mk(512, 0, 1, 0), 0, w}};
		rows = {rows, stim_row_t'{mk(256, 0, 1, 0), 0, w}};
		rows = {rows, stim_row_t'{mk(0, 256, 1, 1), 1, w}};
		rows = {rows, stim_row_t'{mk(256, 0, 1, 0), 0, w}};
		w.point_index = 0;
		rows = {rows, stim_row_t'{mk(5, 5, 0, 0), 1, w}};
		rows = {rows, stim_row_t'{mk(0, 0, 0, 1), 1, '0}};
		foreach (rows[i]) begin
			send_item(rows[i].it);
			if (rows[i].known && verdicts[$] != rows[i].want) begin
				$display("%0t: table row %0d expected %p", $realtime, i, rows[i].want);
				errors++;
			end
		end
		wait_drain();

		// extremes of center and registers, plus overlong measure
		set_circle(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_item(mk(8388607, -8388608, 1, 1));
		send_item(mk(-8388608, 8388607, 1, 1));
		wait_drain();
		set_circle(24'd100, -24'd300, 24'd2000, 24'd400);
		for (int i = 0; i < 300; i++)
			send_item(mk(100 + 2000 - (i == 270 ? 0 : 300), -300, 1, i == 299));
		wait_drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 59 : 0;
			recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 20 : 0;
			set_circle(24'($urandom), 24'($urandom),
				24'($urandom_range(8388607) >> $urandom_range(22)),
				24'($urandom_range(8388607) >> $urandom_range(22)));
			if (ph == 2) hold_cycles <= 3000;
			for (int k = 0; k < 100; k++)
				random_measure($urandom_range(7) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 5));
			wait_drain();
		end

		if (verdicts.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, verdicts.size());
			errors++;
		end
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
sv/cis_pkg.sv
sv/cis_front.sv
sv/cis_fifo.sv
sv/cis_back.sv
sv/circle_inlier_select.sv
test/tb.sv
